FILE: sv/sdpf_pkg.sv
// Package for the soft disk pair force block: types, constants and helpers.
package sdpf_pkg;

   localparam int FRAC_BITS = 24;
   localparam int NUM_W     = 84;
   localparam int DEN_W     = 62;
   localparam int QUO_W     = 49;

   localparam logic [30:0] BOX_RESET   = 31'd691825279;
   localparam logic [15:0] COUNT_RESET = 16'd1024;
   localparam logic [30:0] FORCE_MAX   = 31'h7FFF_FFFF;
   localparam logic [24:0] ONE_Q       = 25'(1) << FRAC_BITS;

   typedef struct packed {
      logic               start_frame;
      logic signed [31:0] own_x;
      logic signed [31:0] own_y;
      logic signed [31:0] neighbour_x;
      logic signed [31:0] neighbour_y;
      logic [15:0]        diameter_own;
      logic [15:0]        diameter_neighbour;
   } sdpf_req_type;

   typedef struct packed {
      logic               in_contact;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [47:0] energy_sum;
      logic signed [47:0] pressure_sum;
      logic signed [47:0] stress_sum;
   } sdpf_rsp_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } sdpf_div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quo;
   } sdpf_div_rsp_type;

   typedef enum logic [1:0] {
      CSR_BOX_LENGTH     = 2'd0,
      CSR_SHEAR_STRAIN   = 2'd1,
      CSR_PARTICLE_COUNT = 2'd2
   } sdpf_csr_type;

   typedef enum logic [1:0] {
      WRAP_NONE = 2'd0,
      WRAP_SUB  = 2'd1,
      WRAP_ADD  = 2'd2
   } sdpf_wrap_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SHIFT, ST_WRAPY, ST_WRAPYX, ST_WRAPX, ST_CHECK,
      ST_DD, ST_YY, ST_AA, ST_SQRT, ST_RSET, ST_R, ST_GSET, ST_G,
      ST_GXL, ST_GXH, ST_FX, ST_GYL, ST_GYH, ST_FY, ST_DYM, ST_ADR, ST_SQ,
      ST_GG, ST_EN, ST_LL, ST_RG, ST_PR, ST_SG, ST_STR, ST_DONE
   } sdpf_state_type;

   // acc +/- min(q, 2^48), clamped to the 48 bit signed range
   function automatic logic signed [47:0] sat_add(input logic signed [47:0] acc,
                                                   input logic [QUO_W-1:0] q,
                                                   input logic neg);
      logic [48:0]        mag;
      logic signed [49:0] v;
      mag = q[48] ? 49'h1_0000_0000_0000 : q;
      if (neg) begin
         v = {{2{acc[47]}}, acc} - $signed({1'b0, mag});
      end else begin
         v = {{2{acc[47]}}, acc} + $signed({1'b0, mag});
      end
      if (v > 50'sh0_7FFF_FFFF_FFFF) begin
         sat_add = 48'sh7FFF_FFFF_FFFF;
      end else if (v < -50'sh0_8000_0000_0000) begin
         sat_add = 48'sh8000_0000_0000;
      end else begin
         sat_add = v[47:0];
      end
   endfunction

endpackage

FILE: sv/sdpf_div.sv
// Restoring divider, one quotient bit per cycle, saturating quotient.
module sdpf_div import sdpf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  sdpf_div_req_type div_req,
   output sdpf_div_rsp_type div_rsp
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0] low_ff, low_in;
   logic [QUO_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] hi;
   logic [DEN_W:0]   rs;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      q_ff   <= q_in;
   end

   assign hi = DEN_W'(div_req.num[NUM_W-1:QUO_W]);
   assign rs = {rem_ff, low_ff[QUO_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      if (busy_ff) begin
         if (rs >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(rs - {1'b0, den_ff});
            q_in   = {q_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = rs[DEN_W-1:0];
            q_in   = {q_ff[QUO_W-2:0], 1'b0};
         end
         low_in = {low_ff[QUO_W-2:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         if (hi >= div_req.den) begin
            // quotient does not fit: report all ones
            q_in    = '1;
            done_in = 1'b1;
         end else begin
            rem_in  = hi;
            low_in  = div_req.num[QUO_W-1:0];
            den_in  = div_req.den;
            cnt_in  = '0;
            busy_in = 1'b1;
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = q_ff;

endmodule

FILE: sv/soft_disk_pair_force.sv
// Top level: harmonic soft disk pair force with sheared periodic images.
//
//  channel  dir  handshake            payload
//  req      in   req_valid/req_ready  sdpf_req_type: pair positions, diameters
//  rsp      out  rsp_valid/rsp_ready  sdpf_rsp_type: contact, force, sums
//  csr      in   csr_we               csr_index, csr_wdata
//
// One request at a time. A pair out of range ends after the wrap and range checks;
// a pair in contact adds a 30 step square root and eight 49 step divisions on the
// shared divider (five if coincident), with combinational 33x33 products between.
// Reset loads the register defaults and clears the three sums.
// A result waiting on rsp_ready holds the block; no request is taken then.
module soft_disk_pair_force import sdpf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  sdpf_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output sdpf_rsp_type rsp_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   sdpf_state_type     state_ff, state_in;
   logic [30:0]        box_ff, box_in;
   logic signed [31:0] strain_ff, strain_in;
   logic [15:0]        count_ff, count_in;
   logic signed [47:0] energy_ff, energy_in;
   logic signed [47:0] pressure_ff, pressure_in;
   logic signed [47:0] stress_ff, stress_in;
   logic signed [40:0] dx_ff, dx_in;
   logic signed [40:0] dy_ff, dy_in;
   logic signed [40:0] shift_ff, shift_in;
   sdpf_wrap_type      ywrap_ff, ywrap_in;
   logic               sx_ff, sx_in;
   logic               sy_ff, sy_in;
   logic               contact_ff, contact_in;
   logic [28:0]        a_ff, a_in;
   logic [28:0]        d_ff, d_in;
   logic [28:0]        y_ff, y_in;
   logic [58:0]        dr2_ff, dr2_in;
   logic [59:0]        root_ff, root_in;
   logic [58:0]        bit_ff, bit_in;
   logic [29:0]        dr_ff, dr_in;
   logic [23:0]        r_ff, r_in;
   logic [24:0]        gap_ff, gap_in;
   logic [37:0]        g_ff, g_in;
   logic [30:0]        fx_ff, fx_in;
   logic [30:0]        fy_ff, fy_in;
   logic [24:0]        sq_ff, sq_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic               div_run_ff, div_run_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic [63:0]        mul_u;
   logic               div_state;
   logic               div_fin;
   logic [QUO_W-1:0]   quo;
   logic signed [41:0] dx2, dy2, lbox2;
   logic signed [40:0] lbox;
   logic [40:0]        magx, magy;
   logic [41:0]        dmag2, ymag2, a2;
   logic [59:0]        sq_t;
   logic [15:0]        n_eff;
   logic [30:0]        q_force;

   sdpf_div_req_type   div_req;
   sdpf_div_rsp_type   div_rsp;

   sdpf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         box_ff      <= BOX_RESET;
         strain_ff   <= '0;
         count_ff    <= COUNT_RESET;
         energy_ff   <= '0;
         pressure_ff <= '0;
         stress_ff   <= '0;
         div_run_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         box_ff      <= box_in;
         strain_ff   <= strain_in;
         count_ff    <= count_in;
         energy_ff   <= energy_in;
         pressure_ff <= pressure_in;
         stress_ff   <= stress_in;
         div_run_ff  <= div_run_in;
      end
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      shift_ff   <= shift_in;
      ywrap_ff   <= ywrap_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      contact_ff <= contact_in;
      a_ff       <= a_in;
      d_ff       <= d_in;
      y_ff       <= y_in;
      dr2_ff     <= dr2_in;
      root_ff    <= root_in;
      bit_ff     <= bit_in;
      dr_ff      <= dr_in;
      r_ff       <= r_in;
      gap_ff     <= gap_in;
      g_ff       <= g_in;
      fx_ff      <= fx_in;
      fy_ff      <= fy_in;
      sq_ff      <= sq_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
   end

   // shared multiplier, operands picked by the sequencer
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SHIFT: begin
            mul_a = {2'b0, box_ff};
            mul_b = {strain_ff[31], strain_ff};
         end
         ST_DD:  begin mul_a = {4'b0, d_ff};           mul_b = {4'b0, d_ff}; end
         ST_YY:  begin mul_a = {4'b0, y_ff};           mul_b = {4'b0, y_ff}; end
         ST_AA:  begin mul_a = {4'b0, a_ff};           mul_b = {4'b0, a_ff}; end
         ST_GXL: begin mul_a = {1'b0, g_ff[31:0]};     mul_b = {4'b0, d_ff}; end
         ST_GXH: begin mul_a = {27'b0, g_ff[37:32]};   mul_b = {4'b0, d_ff}; end
         ST_GYL: begin mul_a = {1'b0, g_ff[31:0]};     mul_b = {4'b0, y_ff}; end
         ST_GYH: begin mul_a = {27'b0, g_ff[37:32]};   mul_b = {4'b0, y_ff}; end
         ST_DYM: begin mul_a = {4'b0, d_ff};           mul_b = {4'b0, y_ff}; end
         ST_ADR: begin mul_a = {4'b0, a_ff};           mul_b = {3'b0, dr_ff}; end
         ST_GG:  begin mul_a = {8'b0, gap_ff};         mul_b = {8'b0, gap_ff}; end
         ST_LL:  begin mul_a = {2'b0, box_ff};         mul_b = {2'b0, box_ff}; end
         ST_RG:  begin mul_a = {9'b0, r_ff};           mul_b = {8'b0, gap_ff}; end
         ST_SG:  begin mul_a = {8'b0, sq_ff};          mul_b = {8'b0, gap_ff}; end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign mul_u = mul_p[63:0];

   assign div_state = (state_ff == ST_R)  || (state_ff == ST_G)  || (state_ff == ST_FX) ||
                      (state_ff == ST_FY) || (state_ff == ST_SQ) || (state_ff == ST_EN) ||
                      (state_ff == ST_PR) || (state_ff == ST_STR);
   assign div_req.start = div_state && !div_run_ff;
   assign div_req.num   = num_ff;
   assign div_req.den   = den_ff;
   assign div_fin       = div_run_ff && div_rsp.done;
   assign quo           = div_rsp.quo;
   assign q_force       = (|quo[QUO_W-1:31]) ? FORCE_MAX : quo[30:0];

   assign lbox  = $signed({10'b0, box_ff});
   assign lbox2 = $signed({11'b0, box_ff});
   assign dx2   = {dx_ff, 1'b0};
   assign dy2   = {dy_ff, 1'b0};
   assign magx  = dx_ff[40] ? 41'(-dx_ff) : 41'(dx_ff);
   assign magy  = dy_ff[40] ? 41'(-dy_ff) : 41'(dy_ff);
   assign dmag2 = {magx, 1'b0};
   assign ymag2 = {magy, 1'b0};
   assign a2    = {13'b0, a_ff};
   assign sq_t  = root_ff + {1'b0, bit_ff};
   assign n_eff = (count_ff == 16'd0) ? 16'd1 : count_ff;

   always_comb begin
      state_in    = state_ff;
      box_in      = box_ff;
      strain_in   = strain_ff;
      count_in    = count_ff;
      energy_in   = energy_ff;
      pressure_in = pressure_ff;
      stress_in   = stress_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      shift_in    = shift_ff;
      ywrap_in    = ywrap_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      contact_in  = contact_ff;
      a_in        = a_ff;
      d_in        = d_ff;
      y_in        = y_ff;
      dr2_in      = dr2_ff;
      root_in     = root_ff;
      bit_in      = bit_ff;
      dr_in       = dr_ff;
      r_in        = r_ff;
      gap_in      = gap_ff;
      g_in        = g_ff;
      fx_in       = fx_ff;
      fy_in       = fy_ff;
      sq_in       = sq_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      div_run_in  = div_run_ff;

      if (csr_we) begin
         case (sdpf_csr_type'(csr_index))
            CSR_BOX_LENGTH:     box_in    = csr_wdata[30:0];
            CSR_SHEAR_STRAIN:   strain_in = $signed(csr_wdata);
            CSR_PARTICLE_COUNT: count_in  = csr_wdata[15:0];
            default:            ;
         endcase
      end

      if (div_req.start) begin
         div_run_in = 1'b1;
      end else if (div_fin) begin
         div_run_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dx_in = {{9{req_data.own_x[31]}}, req_data.own_x} -
                       {{9{req_data.neighbour_x[31]}}, req_data.neighbour_x};
               dy_in = {{9{req_data.own_y[31]}}, req_data.own_y} -
                       {{9{req_data.neighbour_y[31]}}, req_data.neighbour_y};
               a_in  = {({1'b0, req_data.diameter_own} +
                         {1'b0, req_data.diameter_neighbour}), 12'b0};
               contact_in = 1'b0;
               fx_in      = '0;
               fy_in      = '0;
               sq_in      = '0;
               if (req_data.start_frame) begin
                  energy_in   = '0;
                  pressure_in = '0;
                  stress_in   = '0;
               end
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // arithmetic shift is the floor of L*gamma in Q.F
            shift_in = mul_p[FRAC_BITS+40:FRAC_BITS];
            state_in = ST_WRAPY;
         end
         ST_WRAPY: begin
            ywrap_in = WRAP_NONE;
            if (dy2 > lbox2) begin
               dy_in    = dy_ff - lbox;
               ywrap_in = WRAP_SUB;
            end else if (dy2 < -lbox2) begin
               dy_in    = dy_ff + lbox;
               ywrap_in = WRAP_ADD;
            end
            state_in = ST_WRAPYX;
         end
         ST_WRAPYX: begin
            case (ywrap_ff)
               WRAP_SUB: dx_in = dx_ff - shift_ff;
               WRAP_ADD: dx_in = dx_ff + shift_ff;
               default:  dx_in = dx_ff;
            endcase
            state_in = ST_WRAPX;
         end
         ST_WRAPX: begin
            if (dx2 > lbox2) begin
               dx_in = dx_ff - lbox;
            end else if (dx2 < -lbox2) begin
               dx_in = dx_ff + lbox;
            end
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            sx_in = dx_ff[40];
            sy_in = dy_ff[40];
            d_in  = dmag2[28:0];
            y_in  = ymag2[28:0];
            if ((dmag2 < a2) && (ymag2 < a2)) begin
               state_in = ST_DD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DD: begin
            dr2_in   = mul_u[58:0];
            state_in = ST_YY;
         end
         ST_YY: begin
            dr2_in   = dr2_ff + mul_u[58:0];
            state_in = ST_AA;
         end
         ST_AA: begin
            if ({5'b0, dr2_ff} < mul_u) begin
               contact_in = 1'b1;
               root_in    = '0;
               bit_in     = 59'(1) << 58;
               state_in   = ST_SQRT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SQRT: begin
            if ({1'b0, dr2_ff} >= sq_t) begin
               dr2_in  = dr2_ff - sq_t[58:0];
               root_in = (root_ff >> 1) + {1'b0, bit_ff};
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = ST_RSET;
            end
         end
         ST_RSET: begin
            dr_in    = root_ff[29:0];
            num_in   = {30'b0, root_ff[29:0], 24'b0};
            den_in   = {33'b0, a_ff};
            state_in = ST_R;
         end
         ST_R: begin
            if (div_fin) begin
               r_in     = quo[23:0];
               gap_in   = ONE_Q - {1'b0, quo[23:0]};
               state_in = ST_GSET;
            end
         end
         ST_GSET: begin
            num_in   = {34'b0, gap_ff, 25'b0};
            den_in   = {33'b0, a_ff};
            state_in = ST_G;
         end
         ST_G: begin
            if (div_fin) begin
               g_in = quo[37:0];
               // coincident disks: no force, no stress term
               state_in = (dr_ff == 30'd0) ? ST_GG : ST_GXL;
            end
         end
         ST_GXL: begin
            num_in   = {20'b0, mul_u};
            state_in = ST_GXH;
         end
         ST_GXH: begin
            num_in   = num_ff + {mul_u[51:0], 32'b0};
            den_in   = {32'b0, dr_ff};
            state_in = ST_FX;
         end
         ST_FX: begin
            if (div_fin) begin
               fx_in    = q_force;
               state_in = ST_GYL;
            end
         end
         ST_GYL: begin
            num_in   = {20'b0, mul_u};
            state_in = ST_GYH;
         end
         ST_GYH: begin
            num_in   = num_ff + {mul_u[51:0], 32'b0};
            den_in   = {32'b0, dr_ff};
            state_in = ST_FY;
         end
         ST_FY: begin
            if (div_fin) begin
               fy_in    = q_force;
               state_in = ST_DYM;
            end
         end
         ST_DYM: begin
            num_in   = {mul_u[59:0], 24'b0};
            state_in = ST_ADR;
         end
         ST_ADR: begin
            den_in   = mul_u[61:0];
            state_in = ST_SQ;
         end
         ST_SQ: begin
            if (div_fin) begin
               sq_in    = quo[24:0];
               state_in = ST_GG;
            end
         end
         ST_GG: begin
            num_in   = {26'b0, mul_u[49:0], 8'b0};
            den_in   = {21'b0, n_eff, 25'b0};
            state_in = ST_EN;
         end
         ST_EN: begin
            if (div_fin) begin
               energy_in = sat_add(energy_ff, quo, 1'b0);
               state_in  = ST_LL;
            end
         end
         ST_LL: begin
            den_in   = (box_ff == 31'd0) ? 62'd1 : mul_u[61:0];
            state_in = ST_RG;
         end
         ST_RG: begin
            num_in   = {4'b0, mul_u[48:0], 31'b0};
            state_in = ST_PR;
         end
         ST_PR: begin
            if (div_fin) begin
               pressure_in = sat_add(pressure_ff, quo, 1'b0);
               state_in    = ST_SG;
            end
         end
         ST_SG: begin
            num_in   = {4'b0, mul_u[48:0], 31'b0};
            state_in = ST_STR;
         end
         ST_STR: begin
            if (div_fin) begin
               stress_in = sat_add(stress_ff, quo, sx_ff ^ sy_ff);
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   assign rsp_data.in_contact   = contact_ff;
   assign rsp_data.force_x      = sx_ff ? -$signed({1'b0, fx_ff}) : $signed({1'b0, fx_ff});
   assign rsp_data.force_y      = sy_ff ? -$signed({1'b0, fy_ff}) : $signed({1'b0, fy_ff});
   assign rsp_data.energy_sum   = energy_ff;
   assign rsp_data.pressure_sum = pressure_ff;
   assign rsp_data.stress_sum   = stress_ff;

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   a_zero_force: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.in_contact) |->
         (rsp_data.force_x == 32'sd0 && rsp_data.force_y == 32'sd0))
      else $error("force without contact");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (div_run_ff && div_state))
      else $error("divider finished outside a division step");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> div_run_ff)
      else $error("division step lost its run flag");
`endif

endmodule

FILE: sim/tb_soft_disk_pair_force.sv
// Testbench for soft_disk_pair_force: random pairs, shadow predictor, scoreboard.
`timescale 1ns / 1ps
module tb_soft_disk_pair_force;
   import sdpf_pkg::*;

   localparam longint LIMIT = 3_000_000;
   localparam longint ONE = 64'd1 << FRAC_BITS;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   sdpf_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   sdpf_rsp_type rsp_data;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = CSR_BOX_LENGTH;
   logic [31:0]  csr_wdata = '0;

   soft_disk_pair_force dut (.*);

   always #10 clock = ~clock;

   // shadow registers and running sums
   longint        box_len, strain, n_part;
   longint        energy_acc, pressure_acc, stress_acc;
   sdpf_req_type  pending_pairs[$];
   sdpf_rsp_type  expected_rsp[$];
   int            errors = 0, contacts = 0, results = 0, pairs_sent = 0;
   int            idle_mode = 0;
   logic          hold_go = 1'b0, hold_done = 1'b0;
   int            hold_cnt = 0;
   longint        cycles = 0;

   function automatic longint unsigned scaled_div(longint unsigned a, longint unsigned b,
                                                  longint unsigned d);
      logic [127:0] p;
      if (d == 0) return 0;
      p = {64'd0, a} * {64'd0, b};
      if (p[127:64] >= d) return 64'hFFFF_FFFF_FFFF_FFFF;
      p = p / {64'd0, d};
      return p[63:0];
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint clamp_acc(longint acc, longint unsigned mag, bit neg);
      longint v;
      if (mag > (64'd1 << 48)) mag = 64'd1 << 48;
      v = neg ? acc - longint'(mag) : acc + longint'(mag);
      if (v > 64'sh7FFF_FFFF_FFFF) v = 64'sh7FFF_FFFF_FFFF;
      if (v < -64'sh8000_0000_0000) v = -64'sh8000_0000_0000;
      return v;
   endfunction

   function automatic sdpf_rsp_type contact_force(sdpf_req_type p);
      sdpf_rsp_type   o;
      longint         dx, dy, prod, shift;
      longint unsigned mx, my, dsum, a2, dd, yy, aa, dr2, dr, r, gap, g, nn, l2;
      longint unsigned fx, fy, sq, term;
      bit             hit;
      fx = 0; fy = 0; sq = 0; hit = 0;
      dx = longint'(p.own_x) - longint'(p.neighbour_x);
      dy = longint'(p.own_y) - longint'(p.neighbour_y);
      dsum = longint'(p.diameter_own) + longint'(p.diameter_neighbour);
      a2 = dsum << (FRAC_BITS - 12);
      if (p.start_frame) begin
         energy_acc = 0; pressure_acc = 0; stress_acc = 0;
      end
      prod = box_len * strain;
      if (prod >= 0) shift = prod >>> FRAC_BITS;
      else shift = -longint'((longint'(-prod) + ONE - 1) >> FRAC_BITS);
      if (2 * dy > box_len) begin
         dy -= box_len; dx -= shift;
      end else if (2 * dy < -box_len) begin
         dy += box_len; dx += shift;
      end
      if (2 * dx > box_len) dx -= box_len;
      else if (2 * dx < -box_len) dx += box_len;
      mx = dx < 0 ? -dx : dx;
      my = dy < 0 ? -dy : dy;
      if (2 * mx < a2 && 2 * my < a2) begin
         dd = 2 * mx; yy = 2 * my; aa = a2;
         dr2 = dd * dd + yy * yy;
         if (dr2 < aa * aa) begin
            hit = 1;
            dr = root_floor(dr2);
            r = scaled_div(dr, ONE, aa);
            gap = ONE - r;
            g = scaled_div(gap, ONE << 1, aa);
            nn = n_part != 0 ? n_part : 1;
            l2 = box_len != 0 ? box_len * box_len : 1;
            if (dr != 0) begin
               fx = scaled_div(g, dd, dr);
               fy = scaled_div(g, yy, dr);
               sq = scaled_div(dd * yy, ONE, aa * dr);
            end
            if (fx > 64'h7FFF_FFFF) fx = 64'h7FFF_FFFF;
            if (fy > 64'h7FFF_FFFF) fy = 64'h7FFF_FFFF;
            term = scaled_div(gap, gap << (32 - FRAC_BITS), (2 * nn) << FRAC_BITS);
            energy_acc = clamp_acc(energy_acc, term, 0);
            term = scaled_div(r * gap, 64'd1 << 31, l2);
            pressure_acc = clamp_acc(pressure_acc, term, 0);
            term = scaled_div(sq * gap, 64'd1 << 31, l2);
            stress_acc = clamp_acc(stress_acc, term, (dx < 0) != (dy < 0));
         end
      end
      o.in_contact = hit;
      o.force_x = 32'(dx < 0 ? -fx : fx);
      o.force_y = 32'(dy < 0 ? -fy : fy);
      o.energy_sum = 48'(energy_acc);
      o.pressure_sum = 48'(pressure_acc);
      o.stress_sum = 48'(stress_acc);
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      sdpf_rsp_type e;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            e = contact_force(req_data);
            if (e.in_contact) contacts++;
            expected_rsp.push_back(e);
            pairs_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_pairs.size() != 0 &&
                $urandom_range(99) >= (idle_mode == 0 ? 31 : idle_mode == 1 ? 54 : 0)) begin
               req_valid <= 1'b1;
               req_data <= pending_pairs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      sdpf_rsp_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results++;
            if (expected_rsp.size() == 0) begin
               $error("unexpected response %p", rsp_data);
               errors++;
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_data.in_contact !== e.in_contact) begin
                  $error("in_contact exp %0d got %0d", e.in_contact, rsp_data.in_contact);
                  errors++;
               end
               if (rsp_data.force_x !== e.force_x) begin
                  $error("force_x exp %0d got %0d", e.force_x, rsp_data.force_x);
                  errors++;
               end
               if (rsp_data.force_y !== e.force_y) begin
                  $error("force_y exp %0d got %0d", e.force_y, rsp_data.force_y);
                  errors++;
               end
               if (rsp_data.energy_sum !== e.energy_sum) begin
                  $error("energy_sum exp %0d got %0d", e.energy_sum, rsp_data.energy_sum);
                  errors++;
               end
               if (rsp_data.pressure_sum !== e.pressure_sum) begin
                  $error("pressure_sum exp %0d got %0d", e.pressure_sum, rsp_data.pressure_sum);
                  errors++;
               end
               if (rsp_data.stress_sum !== e.stress_sum) begin
                  $error("stress_sum exp %0d got %0d", e.stress_sum, rsp_data.stress_sum);
                  errors++;
               end
            end
         end
      end
      if (hold_go && !hold_done) begin
         // long back-pressure: block should fill and drop req_ready
         rsp_ready <= 1'b0;
         hold_cnt <= hold_cnt + 1;
         if (hold_cnt == 3000) hold_done <= 1'b1;
      end else begin
         rsp_ready <= $urandom_range(99) >= (idle_mode == 0 ? 54 : idle_mode == 1 ? 31 : 0);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_reg(sdpf_csr_type idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BOX_LENGTH:   box_len = longint'(val[30:0]);
         CSR_SHEAR_STRAIN: strain = longint'($signed(val));
         default:          n_part = longint'(val[15:0]);
      endcase
   endtask

   task automatic wait_drained();
      wait (pending_pairs.size() == 0 && !req_valid && expected_rsp.size() == 0);
      @(posedge clock);
   endtask

   task automatic push_pair(bit sf, longint ox, longint oy, longint nx, longint ny,
                            int d1, int d2);
      sdpf_req_type p;
      p.start_frame = sf;
      p.own_x = 32'(ox); p.own_y = 32'(oy);
      p.neighbour_x = 32'(nx); p.neighbour_y = 32'(ny);
      p.diameter_own = 16'(d1); p.diameter_neighbour = 16'(d2);
      pending_pairs.push_back(p);
   endtask

   // well-formed pairs mostly; some straddle the box edge, some are pure noise
   task automatic random_pairs(int count);
      longint ox, oy, lim, ddx, ddy, half;
      int d1, d2, kind;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(9);
         d1 = $urandom_range(65535);
         d2 = $urandom_range(65535);
         lim = ((longint'(d1) + d2) << 11) * 7 / 10 + 1;
         ddx = longint'($urandom_range(0, 32'(2 * lim))) - lim;
         ddy = longint'($urandom_range(0, 32'(2 * lim))) - lim;
         ox = longint'($signed($urandom)) >>> 2;
         oy = longint'($signed($urandom)) >>> 2;
         half = box_len / 2;
         if (kind < 4) begin
            push_pair($urandom_range(19) == 0, ox, oy, ox - ddx, oy - ddy, d1, d2);
         end else if (kind < 6) begin
            push_pair($urandom_range(19) == 0, ox, half - (ddy >>> 1),
                      ox - ddx, -half + (ddy >>> 1), d1, d2);
         end else if (kind == 6) begin
            push_pair(0, half - (ddx >>> 1), oy, -half + (ddx >>> 1), oy - ddy, d1, d2);
         end else begin
            push_pair($urandom_range(1), longint'($signed($urandom)),
                      longint'($signed($urandom)), longint'($signed($urandom)),
                      longint'($signed($urandom)), d1, d2);
         end
      end
   endtask

   initial begin
      box_len = 691825279; strain = 0; n_part = 1024;
      energy_acc = 0; pressure_acc = 0; stress_acc = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: zero sizes, coincident disks, extremes, wraps, frame clear
      push_pair(0, 0, 0, 0, 0, 0, 0);
      push_pair(0, 0, 0, 0, 0, 65535, 65535);
      push_pair(0, 100, 200, 100, 200, 1, 0);
      push_pair(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh8000_0000, -32'sh8000_0000,
                65535, 65535);
      push_pair(0, -32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh8000_0000,
                65535, 0);
      push_pair(0, 1 << 20, 3 << 20, 0, 0, 4096, 4096);
      push_pair(0, -(1 << 22), 1 << 21, 0, 0, 4096, 8192);
      push_pair(0, 0, 345000000, 0, -345000000, 8192, 8192);
      push_pair(0, 345000000, 0, -345000000, 0, 8192, 8192);
      push_pair(1, 5 << 20, -(7 << 20), 0, 0, 65535, 65535);
      push_pair(0, 0, 1 << 23, 0, 0, 4096, 4096);
      push_pair(0, 1 << 23, 1, 0, 0, 4096, 4096);
      push_pair(1, 0, 0, 1 << 25, 0, 4096, 4096);
      wait_drained();

      write_reg(CSR_SHEAR_STRAIN, 32'h0080_0000);
      push_pair(0, 0, 345000000, 0, -345000000, 8192, 8192);
      push_pair(0, 1 << 20, -345000000, 0, 345000000, 16384, 8192);
      random_pairs(400);
      wait_drained();

      idle_mode = 1;
      write_reg(CSR_BOX_LENGTH, 32'h7FFF_FFFF);
      write_reg(CSR_SHEAR_STRAIN, 32'h8000_0000);
      write_reg(CSR_PARTICLE_COUNT, 32'd65535);
      random_pairs(300);
      wait_drained();

      write_reg(CSR_BOX_LENGTH, 32'd1);
      write_reg(CSR_SHEAR_STRAIN, 32'h7FFF_FFFF);
      write_reg(CSR_PARTICLE_COUNT, 32'd1);
      random_pairs(200);
      wait_drained();

      idle_mode = 2;
      write_reg(CSR_BOX_LENGTH, $urandom_range(1 << 24, 32'h7FFF_FFFF));
      write_reg(CSR_SHEAR_STRAIN, $urandom);
      write_reg(CSR_PARTICLE_COUNT, $urandom_range(1, 65535));
      hold_go = 1'b1;
      random_pairs(300);
      wait_drained();

      write_reg(CSR_BOX_LENGTH, 32'd691825279);
      write_reg(CSR_SHEAR_STRAIN, $urandom_range(0, 1 << 24));
      write_reg(CSR_PARTICLE_COUNT, 32'd1024);
      random_pairs(300);
      wait_drained();

      repeat (600) @(posedge clock);
      $display("Sent %0d pairs over six register settings, %0d in contact, %0d responses.",
               pairs_sent, contacts, results);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
